// File: src/bracket_matrix_literal_parser_core_assert.svh
// Assertion macros used by the checker file.
`ifndef BRACKET_MATRIX_LITERAL_PARSER_CORE_ASSERT_SVH
`define BRACKET_MATRIX_LITERAL_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, ignored during reset.
`define BMLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored during reset.
`define BMLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bmlp_pkg.sv
`timescale 1ns / 1ps

package bmlp_pkg;

   localparam int MAX_DIM = 16;
   // Counters must hold MAX_DIM itself.
   localparam int CNT_W   = $clog2(MAX_DIM + 1);

   typedef enum logic [2:0] {
      PH_OPEN,
      PH_AFTER_OPEN,
      PH_ELEM,
      PH_SEP,
      PH_AFTER_ROW,
      PH_TAIL
   } phase_type;

   localparam logic [1:0] ST_NONE  = 2'd0;
   localparam logic [1:0] ST_ELEM  = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;
   localparam logic [1:0] ST_ERROR = 2'd3;

   localparam logic [3:0] E_NONE          = 4'd0;
   localparam logic [3:0] E_NO_OPEN       = 4'd1;
   localparam logic [3:0] E_EMPTY_OPEN    = 4'd2;
   localparam logic [3:0] E_ROW_BRACKET   = 4'd3;
   localparam logic [3:0] E_MISSING_ELEM  = 4'd4;
   localparam logic [3:0] E_BAD_SEP       = 4'd5;
   localparam logic [3:0] E_RAGGED        = 4'd6;
   localparam logic [3:0] E_BAD_AFTER_ROW = 4'd7;
   localparam logic [3:0] E_NOT_SQUARE    = 4'd8;
   localparam logic [3:0] E_TRAILING      = 4'd9;
   localparam logic [3:0] E_TOO_LARGE     = 4'd10;

   localparam logic       CMD_CHAR = 1'b0;
   localparam logic       CMD_END  = 1'b1;

   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] elem_value;
      logic       is_variable;
      logic [3:0] elem_row;
      logic [3:0] elem_col;
      logic [3:0] error_code;
      logic [4:0] matrix_size;
   } result_type;

endpackage

// File: src/bmlp_if.sv
`timescale 1ns / 1ps

interface bmlp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] char_in;

   modport source (output valid, output cmd, output char_in, input ready);
   modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

interface bmlp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] elem_value;
   logic       is_variable;
   logic [3:0] elem_row;
   logic [3:0] elem_col;
   logic [3:0] error_code;
   logic [4:0] matrix_size;

   modport source (output valid, output status, output elem_value, output is_variable,
                   output elem_row, output elem_col, output error_code,
                   output matrix_size, input ready);
   modport sink   (input valid, input status, input elem_value, input is_variable,
                   input elem_row, input elem_col, input error_code,
                   input matrix_size, output ready);
endinterface

// File: src/bmlp_parser.sv
`timescale 1ns / 1ps

module bmlp_parser
   import bmlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       cmd,
   input  logic [7:0] char_in,
   output result_type result
);

   phase_type        phase_ff, phase_in;
   logic [3:0]       sticky_ff, sticky_in;
   logic [7:0]       held_ff, held_in;
   logic [CNT_W-1:0] column_ff, column_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] width_ff, width_in;
   logic             known_ff, known_in;

   logic             blank, is_open, is_close, is_comma;
   logic             char_active;
   logic [CNT_W-1:0] len;
   logic [3:0]       err_hit;
   logic [3:0]       end_code;

   assign blank    = (char_in == 8'h20) || (char_in >= 8'h09 && char_in <= 8'h0D);
   assign is_open  = (char_in == CH_OPEN);
   assign is_close = (char_in == CH_CLOSE);
   assign is_comma = (char_in == CH_COMMA);
   assign len      = column_ff + CNT_W'(1);
   assign char_active = (cmd == CMD_CHAR) && (sticky_ff == E_NONE) && !blank;

   // Error raised by the current character, if any.
   always_comb begin
      err_hit = E_NONE;
      case (phase_ff)
         PH_OPEN: begin
            if (!is_open) err_hit = E_NO_OPEN;
         end
         PH_AFTER_OPEN: begin
            if (is_close)     err_hit = E_NOT_SQUARE;
            else if (!is_open) err_hit = E_ROW_BRACKET;
         end
         PH_ELEM: begin
            err_hit = E_NONE;
         end
         PH_SEP: begin
            if (!is_comma && !is_close)                 err_hit = E_BAD_SEP;
            else if (column_ff >= CNT_W'(MAX_DIM))      err_hit = E_TOO_LARGE;
            else if (is_close && known_ff && width_ff != len) err_hit = E_RAGGED;
         end
         PH_AFTER_ROW: begin
            if (is_open) begin
               if (row_ff >= CNT_W'(MAX_DIM)) err_hit = E_TOO_LARGE;
            end else if (!is_close) begin
               err_hit = E_BAD_AFTER_ROW;
            end else if (width_ff != row_ff) begin
               err_hit = E_NOT_SQUARE;
            end
         end
         default: err_hit = E_TRAILING;
      endcase
   end

   // Error reported at end of text when nothing went wrong earlier.
   always_comb begin
      case (phase_ff)
         PH_OPEN:       end_code = E_NO_OPEN;
         PH_AFTER_OPEN: end_code = E_EMPTY_OPEN;
         PH_ELEM:       end_code = E_MISSING_ELEM;
         PH_SEP:        end_code = E_BAD_SEP;
         PH_AFTER_ROW:  end_code = E_BAD_AFTER_ROW;
         default:       end_code = E_NONE;
      endcase
   end

   // Next state.
   always_comb begin
      phase_in  = phase_ff;
      sticky_in = sticky_ff;
      held_in   = held_ff;
      column_in = column_ff;
      row_in    = row_ff;
      width_in  = width_ff;
      known_in  = known_ff;
      if (accept) begin
         if (cmd == CMD_END) begin
            phase_in  = PH_OPEN;
            sticky_in = E_NONE;
            held_in   = '0;
            column_in = '0;
            row_in    = '0;
            width_in  = '0;
            known_in  = 1'b0;
         end else if (char_active) begin
            if (err_hit != E_NONE) begin
               sticky_in = err_hit;
            end else begin
               case (phase_ff)
                  PH_OPEN: begin
                     phase_in = PH_AFTER_OPEN;
                  end
                  PH_AFTER_OPEN: begin
                     column_in = '0;
                     phase_in  = PH_ELEM;
                  end
                  PH_ELEM: begin
                     held_in  = char_in;
                     phase_in = PH_SEP;
                  end
                  PH_SEP: begin
                     if (is_close) begin
                        if (!known_ff) begin
                           width_in = len;
                           known_in = 1'b1;
                        end
                        phase_in  = PH_AFTER_ROW;
                        row_in    = row_ff + CNT_W'(1);
                        column_in = '0;
                     end else begin
                        phase_in  = PH_ELEM;
                        column_in = len;
                     end
                  end
                  PH_AFTER_ROW: begin
                     if (is_open) begin
                        column_in = '0;
                        phase_in  = PH_ELEM;
                     end else begin
                        phase_in = PH_TAIL;
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
      end
   end

   // Result for the item at the input.
   always_comb begin
      logic [3:0] code;
      code   = (sticky_ff != E_NONE) ? sticky_ff : end_code;
      result = '0;
      if (cmd == CMD_END) begin
         if (code == E_NONE) begin
            result.status      = ST_DONE;
            result.matrix_size = 5'(row_ff);
         end else begin
            result.status     = ST_ERROR;
            result.error_code = code;
         end
      end else if (char_active && err_hit != E_NONE) begin
         result.status     = ST_ERROR;
         result.error_code = err_hit;
      end else if (char_active && phase_ff == PH_SEP) begin
         result.status   = ST_ELEM;
         result.elem_row = 4'(row_ff);
         result.elem_col = 4'(column_ff);
         if (held_ff >= CH_ZERO && held_ff <= CH_NINE) begin
            result.elem_value  = held_ff - CH_ZERO;
            result.is_variable = 1'b0;
         end else begin
            result.elem_value  = held_ff;
            result.is_variable = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPEN;
         sticky_ff <= E_NONE;
         held_ff   <= '0;
         column_ff <= '0;
         row_ff    <= '0;
         width_ff  <= '0;
         known_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         sticky_ff <= sticky_in;
         held_ff   <= held_in;
         column_ff <= column_in;
         row_ff    <= row_in;
         width_ff  <= width_in;
         known_ff  <= known_in;
      end
   end

endmodule

// File: src/bmlp_out_buf.sv
`timescale 1ns / 1ps

module bmlp_out_buf
   import bmlp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  result_type push_data,
   output logic       push_ready,
   output logic       pop_valid,
   output result_type pop_data,
   input  logic       pop_ready
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       push, pop;

   assign push_ready = !skid_valid_ff;
   assign push       = push_valid && push_ready;
   assign pop        = main_valid_ff && pop_ready;
   assign pop_valid  = main_valid_ff;
   assign pop_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            // no push possible while the skid entry is full
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

// File: src/bracket_matrix_literal_parser_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                              Handshake
// req_chan  in   cmd, char_in                                          valid/ready
// rsp_chan  out  status, elem_value, is_variable, elem_row, elem_col,  valid/ready
//                error_code, matrix_size
//
// One request per cycle while req ready is high; one response per request, in the
// cycle after acceptance when the output register is free, else it waits in the skid.
// The per-character decode is a single combinational step on the parser state.
// Responses sit in a two-entry output buffer (register plus skid), so requests
// keep flowing while one response waits; req ready drops only when both are full.
// Reset is synchronous, active high; it empties the buffer and puts the parser
// back to expecting the outer opening bracket.

module bracket_matrix_literal_parser_core
   import bmlp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   bmlp_req_if.sink  req_chan,
   bmlp_rsp_if.source rsp_chan
);

   logic       req_fire;
   logic       buf_ready;
   logic       rsp_valid;
   result_type step_result;
   result_type rsp_data;

   // A request is taken whenever the skid slot is free.
   assign req_chan.ready = buf_ready;
   assign req_fire       = req_chan.valid && buf_ready;

   // State update and response decode for the request at the port.
   bmlp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_fire),
      .cmd     (req_chan.cmd),
      .char_in (req_chan.char_in),
      .result  (step_result)
   );

   // Every request produces exactly one response.
   bmlp_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_chan.valid),
      .push_data  (step_result),
      .push_ready (buf_ready),
      .pop_valid  (rsp_valid),
      .pop_data   (rsp_data),
      .pop_ready  (rsp_chan.ready)
   );

   assign rsp_chan.valid       = rsp_valid;
   assign rsp_chan.status      = rsp_data.status;
   assign rsp_chan.elem_value  = rsp_data.elem_value;
   assign rsp_chan.is_variable = rsp_data.is_variable;
   assign rsp_chan.elem_row    = rsp_data.elem_row;
   assign rsp_chan.elem_col    = rsp_data.elem_col;
   assign rsp_chan.error_code  = rsp_data.error_code;
   assign rsp_chan.matrix_size = rsp_data.matrix_size;

endmodule

// File: src/bmlp_checker.sv
`timescale 1ns / 1ps
`include "bracket_matrix_literal_parser_core_assert.svh"

module bmlp_checker
   import bmlp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_elem_value,
   input logic       rsp_is_variable,
   input logic [3:0] rsp_elem_row,
   input logic [3:0] rsp_elem_col,
   input logic [3:0] rsp_error_code,
   input logic [4:0] rsp_matrix_size
);

   `BMLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_error_code), "response dropped or changed while stalled")

   `BMLP_ASSERT_NEXT(a_end_responds, clock, reset, req_valid && req_ready && req_cmd == CMD_END, rsp_valid, "no response after end of text")

   `BMLP_ASSERT_NOW(a_error_coded, clock, reset, rsp_valid, (rsp_status == ST_ERROR) == (rsp_error_code != E_NONE), "error code does not match status")

   `BMLP_ASSERT_NOW(a_size_only_done, clock, reset, rsp_valid && rsp_status != ST_DONE, rsp_matrix_size == 5'd0, "matrix size outside a completion")

   `BMLP_ASSERT_NOW(a_elem_only_emit, clock, reset, rsp_valid && rsp_status != ST_ELEM, rsp_elem_value == 8'd0 && !rsp_is_variable && rsp_elem_row == 4'd0 && rsp_elem_col == 4'd0, "element fields outside an element")

endmodule

bind bracket_matrix_literal_parser_core bmlp_checker u_bmlp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_cmd         (req_chan.cmd),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_elem_value  (rsp_chan.elem_value),
   .rsp_is_variable (rsp_chan.is_variable),
   .rsp_elem_row    (rsp_chan.elem_row),
   .rsp_elem_col    (rsp_chan.elem_col),
   .rsp_error_code  (rsp_chan.error_code),
   .rsp_matrix_size (rsp_chan.matrix_size)
);
